// ===== rtl/rgbc_nearest_color_classifier_unit_defines.svh =====
// ----------------------------------------------------------------------------
// rgbc nearest color classifier assertion macros
// clocked assertion helpers for the classifier unit; define ASSERT_OFF to drop them
// ----------------------------------------------------------------------------
`ifndef RGBC_NEAREST_COLOR_CLASSIFIER_UNIT_DEFINES_SVH
`define RGBC_NEAREST_COLOR_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// implication checked in the same cycle
`define RGBC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define RGBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RGBC_ASSERT_IMP(label, ante, cons, msg)
`define RGBC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/rgbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbc classifier package
// shared widths, codes and types of the nearest color classifier
// ----------------------------------------------------------------------------
`default_nettype none

package rgbc_pkg;

	localparam int NUM_CLASSES_DEF = 5;
	localparam int NUM_CH          = 4;
	localparam int CH_W            = 16;
	localparam int SQ_W            = 2 * CH_W;
	localparam int DIST_W          = 34;
	localparam int ID_W            = 3;
	localparam int CLS_W           = 3;
	localparam int TAG_IDX_W       = 4;   // covers up to 16 classes
	localparam int S_TDATA_W       = 72;
	localparam int M_TDATA_W       = 40;

	localparam logic OP_CLASSIFY  = 1'b0;
	localparam logic OP_CALIBRATE = 1'b1;

	// channel 0 red, 1 green, 2 blue, 3 clear
	typedef logic [NUM_CH-1:0][CH_W-1:0] rgbc_sample_t;

	// tag that follows one reference read down the distance pipeline
	typedef struct packed {
		logic                 vld;
		logic                 last;
		logic [TAG_IDX_W-1:0] idx;
	} rgbc_tag_t;

endpackage

`default_nettype wire

// ===== rtl/rgbc_nearest_color_classifier_unit.sv =====
// a calibrate beat is taken while idle and writes the reference memory at once
// a classify beat reads every reference in turn through the distance pipeline and its result is
// registered from the finish state, later while the previous result is still held on the output
// a new beat is taken only in idle, after the last result is registered: one reference read per
// cycle from the single memory read port, four distance stages behind it, finish and handoff
// reset: arst_n clears control, output valid and the per-class valid bits (references read 0)
// ----------------------------------------------------------------------------
// rgbc nearest color classifier
// stores one rgbc reference per class and returns the nearest class of a sample
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgbc_nearest_color_classifier_unit_defines.svh"

module rgbc_nearest_color_classifier_unit
	import rgbc_pkg::*;
#(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// class_index[2:0], red[18:3], green[34:19], blue[50:35], clear[66:51], zero[71:67]
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// op[0]
	input  wire logic [0:0]           s_axis_tuser,
	// result stream
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// color_id[2:0], min_dist_sq[36:3], zero[39:37]
	output logic [M_TDATA_W-1:0]      m_axis_tdata
);

	localparam int IDX_W = $clog2(NUM_CLASSES);
	localparam int CNT_W = $clog2(NUM_CLASSES + 1);

	// controller states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;        // next reference to read
	rgbc_sample_t      sample_q;     // sample under classification
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  best_id_q;
	logic              m_valid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic         in_beat;
	logic         op;
	logic [CLS_W-1:0] class_index;
	rgbc_sample_t in_sample;
	logic         cal_wr;
	logic         issue;
	rgbc_tag_t    tag_s0;
	rgbc_tag_t    tag_s5;
	rgbc_sample_t ref_s1;
	logic [DIST_W-1:0] dist_s5;
	logic         take_best;
	logic         out_free;

	// input unpack
	assign op          = s_axis_tuser[0];
	assign class_index = s_axis_tdata[CLS_W-1:0];
	assign in_sample   = rgbc_sample_t'(s_axis_tdata[CLS_W +: NUM_CH*CH_W]);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// calibrate writes straight into the memory; out-of-range classes are dropped
	assign cal_wr = in_beat && (op == OP_CALIBRATE) && (int'(class_index) < NUM_CLASSES);

	// one reference read per cycle while classifying
	assign issue       = (state_q == ST_RUN) && (cnt_q < CNT_W'(NUM_CLASSES));
	assign tag_s0.vld  = issue;
	assign tag_s0.last = (cnt_q == CNT_W'(NUM_CLASSES - 1));
	assign tag_s0.idx  = TAG_IDX_W'(cnt_q[IDX_W-1:0]);

	rgbc_ref_mem #(
		.DEPTH (NUM_CLASSES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cal_wr),
		.wr_addr (IDX_W'(class_index)),
		.wr_data (in_sample),
		.rd_en   (issue),
		.rd_addr (cnt_q[IDX_W-1:0]),
		.rd_data (ref_s1)
	);

	rgbc_dist_unit u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_q),
		.tag_s0  (tag_s0),
		.ref_s1  (ref_s1),
		.tag_s5  (tag_s5),
		.dist_s5 (dist_s5)
	);

	// first entry always seeds the running minimum; strict less keeps the lower index on ties
	assign take_best = tag_s5.vld && ((tag_s5.idx == '0) || (dist_s5 < best_dist_q));

	// output register is free when empty or its beat is taken this cycle
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// in finish the register is either refilled or kept
			if (m_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_beat && (op == OP_CLASSIFY)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (tag_s5.vld && tag_s5.last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// wait here while the previous result is still held
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_q <= in_sample;
		end
		if (take_best) begin
			best_dist_q <= dist_s5;
			best_id_q   <= tag_s5.idx[IDX_W-1:0];
		end
		if ((state_q == ST_FIN) && out_free) begin
			m_tdata_q <= {(M_TDATA_W - ID_W - DIST_W)'(0), best_dist_q, ID_W'(best_id_q)};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;

	// distance results only appear while a classify is running
	`RGBC_ASSERT_IMP(a_dist_in_run, tag_s5.vld, state_q == ST_RUN,
		"distance result outside classify")
	// the first reference always seeds the minimum
	`RGBC_ASSERT_NEXT(a_seed_first, tag_s5.vld && (tag_s5.idx == '0), best_id_q == '0,
		"running minimum not seeded by class 0")
	// a new result only comes out of the finish state
	`RGBC_ASSERT_IMP(a_result_src, $rose(m_axis_tvalid), $past(state_q) == ST_FIN,
		"result raised outside finish")
	// reported class is always a stored class
	`RGBC_ASSERT_IMP(a_id_range, m_axis_tvalid, int'(m_axis_tdata[ID_W-1:0]) < NUM_CLASSES,
		"color id out of range")

endmodule

`default_nettype wire

// ===== rtl/rgbc_ref_mem.sv =====
// ----------------------------------------------------------------------------
// rgbc reference memory
// one reference sample per class, registered read, per-entry valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_ref_mem
	import rgbc_pkg::*;
#(
	parameter int DEPTH = NUM_CLASSES_DEF,
	parameter int IDX_W = $clog2(NUM_CLASSES_DEF)
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire rgbc_sample_t wr_data,
	input  wire logic         rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output rgbc_sample_t      rd_data
);

	rgbc_sample_t mem [DEPTH];
	rgbc_sample_t rd_data_q;
	logic [DEPTH-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/rgbc_dist_unit.sv =====
// ----------------------------------------------------------------------------
// rgbc distance unit
// pipelined squared euclidean distance between the sample and one reference
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_dist_unit
	import rgbc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire rgbc_sample_t sample,
	input  wire rgbc_tag_t    tag_s0,
	input  wire rgbc_sample_t ref_s1,
	output rgbc_tag_t    tag_s5,
	output logic [DIST_W-1:0] dist_s5
);

	rgbc_tag_t tag_s1_q, tag_s2_q, tag_s3_q, tag_s4_q, tag_s5_q;
	logic [CH_W-1:0]   diff_s2 [NUM_CH];
	logic [SQ_W-1:0]   sq_s3   [NUM_CH];
	logic [SQ_W:0]     pair_s4 [2];
	logic [DIST_W-1:0] dist_s5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1_q <= '0;
			tag_s2_q <= '0;
			tag_s3_q <= '0;
			tag_s4_q <= '0;
			tag_s5_q <= '0;
		end else begin
			tag_s1_q <= tag_s0;
			tag_s2_q <= tag_s1_q;
			tag_s3_q <= tag_s2_q;
			tag_s4_q <= tag_s3_q;
			tag_s5_q <= tag_s4_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			// absolute difference per channel
			diff_s2[ch] <= (ref_s1[ch] >= sample[ch]) ? ref_s1[ch] - sample[ch]
			                                           : sample[ch] - ref_s1[ch];
			sq_s3[ch]   <= diff_s2[ch] * diff_s2[ch];
		end
		pair_s4[0] <= (SQ_W+1)'(sq_s3[0]) + (SQ_W+1)'(sq_s3[1]);
		pair_s4[1] <= (SQ_W+1)'(sq_s3[2]) + (SQ_W+1)'(sq_s3[3]);
		dist_s5_q  <= DIST_W'(pair_s4[0]) + DIST_W'(pair_s4[1]);
	end

	assign tag_s5  = tag_s5_q;
	assign dist_s5 = dist_s5_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// rgbc nearest color classifier testbench
// drives calibrate and classify beats into the classifier and predicts each
// nearest class and squared distance from a local copy of the reference table;
// results are checked in order against the predictions while both stream
// sides idle and stall at random
// ----------------------------------------------------------------------------

module tb
	import rgbc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_CLASS = NUM_CLASSES_DEF;

	// how a random sample is drawn
	typedef enum int {
		SMP_RANDOM,
		SMP_EXTREME,
		SMP_COPY,
		SMP_NEAR
	} sample_kind_t;

	// one predicted classification
	typedef struct packed {
		logic [ID_W-1:0]   color_id;
		logic [DIST_W-1:0] dist_sq;
	} match_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 s_axis_tvalid  = 1'b0;
	logic                 s_axis_tready;
	// class_index[2:0], red[18:3], green[34:19], blue[50:35], clear[66:51], zero[71:67]
	logic [S_TDATA_W-1:0] s_axis_tdata   = '0;
	// op[0]
	logic [0:0]           s_axis_tuser   = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready  = 1'b0;
	// color_id[2:0], min_dist_sq[36:3], zero[39:37]
	logic [M_TDATA_W-1:0] m_axis_tdata;

	// local copy of the reference store, all zero after reset
	rgbc_sample_t class_refs [N_CLASS] = '{default: '0};
	match_t       expected_matches[$];
	int           err_count      = 0;
	int           src_idle_pct   = 0;
	int           sink_stall_pct = 0;

	rgbc_nearest_color_classifier_unit #(
		.NUM_CLASSES(N_CLASS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		err_count++;
	endtask

	// nearest reference by squared distance, lowest index on ties
	function automatic match_t nearest_class(rgbc_sample_t smp);
		match_t          best;
		logic [DIST_W+1:0] acc;
		logic [CH_W-1:0] diff;
		best = '0;
		for (int k = 0; k < N_CLASS; k++) begin
			acc = '0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				diff = (class_refs[k][ch] >= smp[ch]) ? class_refs[k][ch] - smp[ch]
								      : smp[ch] - class_refs[k][ch];
				acc = acc + diff * diff;
			end
			if (k == 0 || acc < best.dist_sq) begin
				best.color_id = k[ID_W-1:0];
				best.dist_sq  = acc[DIST_W-1:0];
			end
		end
		return best;
	endfunction

	function automatic rgbc_sample_t random_sample(sample_kind_t kind);
		rgbc_sample_t s;
		rgbc_sample_t base;
		int           v;
		int           span;
		base = class_refs[$urandom_range(N_CLASS - 1)];
		case ($urandom_range(2))
			0: span = 4;
			1: span = 256;
			default: span = 8192;
		endcase
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case (kind)
				SMP_RANDOM: s[ch] = CH_W'($urandom);
				SMP_EXTREME: begin
					case ($urandom_range(2))
						0: s[ch] = '0;
						1: s[ch] = '1;
						default: s[ch] = CH_W'($urandom);
					endcase
				end
				SMP_COPY: s[ch] = base[ch];
				default: begin
					// jitter around a stored reference, clamped to the channel range
					v = int'(base[ch]) + int'($urandom_range(2 * span)) - span;
					if (v < 0)
						v = 0;
					else if (v > 65535)
						v = 65535;
					s[ch] = CH_W'(v);
				end
			endcase
		end
		return s;
	endfunction

	// one input beat; tvalid stays high into the next call unless a gap is drawn
	task automatic send_beat(logic op, logic [CLS_W-1:0] cls, rgbc_sample_t smp);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {5'b0, smp[3], smp[2], smp[1], smp[0], cls};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// beat taken at this edge: update the local store or queue a prediction
		if (op == OP_CALIBRATE) begin
			if (cls < N_CLASS)
				class_refs[cls] = smp;
		end else begin
			expected_matches.push_back(nearest_class(smp));
		end
	endtask

	// receiver stalls at random
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

	// in-order check of every result beat
	always @(posedge clk) begin : result_check
		match_t exp_m;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_matches.size() == 0) begin
				report_mismatch($sformatf("unexpected result color_id %0d min_dist_sq %0d",
							  m_axis_tdata[2:0], m_axis_tdata[36:3]));
			end else begin
				exp_m = expected_matches.pop_front();
				if (m_axis_tdata[2:0] !== exp_m.color_id)
					report_mismatch($sformatf("color_id %0d, expected %0d",
								  m_axis_tdata[2:0], exp_m.color_id));
				if (m_axis_tdata[36:3] !== exp_m.dist_sq)
					report_mismatch($sformatf("min_dist_sq %0d, expected %0d",
								  m_axis_tdata[36:3], exp_m.dist_sq));
			end
		end
	end

	// references never written still hold zero and take part
	task automatic test_unwritten_refs();
		send_beat(OP_CLASSIFY, 3'd0, '0);
		send_beat(OP_CLASSIFY, 3'd7, '1);
		send_beat(OP_CLASSIFY, 3'd3, {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
	endtask

	// store every class, try out-of-range classes, classify onto the stored values
	task automatic test_calibrate_store();
		send_beat(OP_CALIBRATE, 3'd0, '1);
		send_beat(OP_CALIBRATE, 3'd1, {NUM_CH{16'h4000}});
		send_beat(OP_CALIBRATE, 3'd2, {16'h0001, 16'h8000, 16'hFFFE, 16'h1234});
		send_beat(OP_CALIBRATE, 3'd3, {NUM_CH{16'hC000}});
		send_beat(OP_CALIBRATE, 3'd4, {NUM_CH{16'h8000}});
		// out of range: a stored zero here would win the zero sample below
		send_beat(OP_CALIBRATE, 3'd5, '0);
		send_beat(OP_CALIBRATE, 3'd6, '0);
		send_beat(OP_CALIBRATE, 3'd7, '0);
		send_beat(OP_CLASSIFY, 3'd0, '0);
		send_beat(OP_CLASSIFY, 3'd7, '1);
		send_beat(OP_CLASSIFY, 3'd5, {NUM_CH{16'h8000}});
		send_beat(OP_CLASSIFY, 3'd2, {16'h0001, 16'h8000, 16'hFFFE, 16'h1234});
	endtask

	// equal distances resolve to the lower class
	task automatic test_tie_break();
		send_beat(OP_CALIBRATE, 3'd1, {NUM_CH{16'd20000}});
		send_beat(OP_CALIBRATE, 3'd2, {NUM_CH{16'd20000}});
		send_beat(OP_CALIBRATE, 3'd3, {NUM_CH{16'd20200}});
		send_beat(OP_CLASSIFY, 3'd6, {NUM_CH{16'd20100}});
		send_beat(OP_CLASSIFY, 3'd1, {NUM_CH{16'd20000}});
		send_beat(OP_CALIBRATE, 3'd0, {NUM_CH{16'd20100}});
		send_beat(OP_CLASSIFY, 3'd4, {NUM_CH{16'd20100}});
	endtask

	// mixed traffic: mostly classify near stored references, some recalibration
	task automatic test_random_traffic(int n_items);
		logic              op;
		logic [CLS_W-1:0]  cls;
		sample_kind_t      kind;
		int                r;
		for (int i = 0; i < n_items; i++) begin
			op = ($urandom_range(99) < 22) ? OP_CALIBRATE : OP_CLASSIFY;
			r  = $urandom_range(99);
			if (op == OP_CALIBRATE) begin
				if ($urandom_range(9) == 0)
					cls = CLS_W'($urandom_range(7, N_CLASS));
				else
					cls = CLS_W'($urandom_range(N_CLASS - 1));
				// copies make duplicate references and so ties
				kind = (r < 50) ? SMP_RANDOM : (r < 75) ? SMP_COPY : SMP_EXTREME;
			end else begin
				cls  = CLS_W'($urandom);
				kind = (r < 50) ? SMP_NEAR : (r < 65) ? SMP_COPY :
				       (r < 85) ? SMP_RANDOM : SMP_EXTREME;
			end
			send_beat(op, cls, random_sample(kind));
		end
	endtask

	initial begin : test_sequence
		src_idle_pct   = 6;
		sink_stall_pct = 78;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unwritten_refs();
		test_calibrate_store();
		test_tie_break();
		test_random_traffic(350);

		src_idle_pct   = 78;
		sink_stall_pct = 6;
		test_random_traffic(350);

		src_idle_pct   = 0;
		sink_stall_pct = 0;
		test_random_traffic(350);

		s_axis_tvalid <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
		// let any stray result show up
		repeat (N_CLASS + 12)
			@(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : run_limit
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rgbc_pkg.sv
rtl/rgbc_ref_mem.sv
rtl/rgbc_dist_unit.sv
rtl/rgbc_nearest_color_classifier_unit.sv
sim/tb.sv
